@@ rtl/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types, codes and defaults of the sorted priority list.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spl_pkg;

   localparam int CAPACITY_DEFAULT   = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OP_W     = 3;
   localparam int INDEX_W  = 4;
   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND    = 3'd0,
      OP_PINSERT   = 3'd1,
      OP_INSERT_AT = 3'd2,
      OP_REMOVE    = 3'd3,
      OP_DROP_LAST = 3'd4,
      OP_READ      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // What the shift stage does to the cell row.
   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_DROP   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPARE = 2'd1,
      S_APPLY   = 2'd2
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic apply;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/spl_req_if.sv @@
// ----------------------------------------------------------------------------
// spl_req_if
// Request channel: one list operation per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spl_req_if
   import spl_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [INDEX_W-1:0]  index;
   logic [DATA_W-1:0]   data;
   logic [PRIO_W-1:0]   priority_req;

   modport source (output valid, op, index, data, priority_req, input ready);
   modport sink   (input valid, op, index, data, priority_req, output ready);
endinterface

`default_nettype wire

@@ rtl/spl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// spl_rsp_if
// Response channel: one result item per operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spl_rsp_if
   import spl_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   read_data;
   logic [PRIO_W-1:0]   read_priority;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, read_data, read_priority, status, entry_count,
                   input ready);
   modport sink   (input valid, read_data, read_priority, status, entry_count,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/sorted_priority_list.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_list
// Bounded ordered list of data words with 8-bit priorities.
// ----------------------------------------------------------------------------
// Each request item carries one operation (append, stable priority insert,
// insert at index, remove at index, drop last, read at index) and yields
// exactly one response item with status and the entry count afterwards.
// Entries live in a row of cells; every cell compares itself against the
// request at once and then the whole row shifts, so an item passes through the
// accept, compare and shift steps whatever the fill level. A new request
// is taken while the previous response is still waiting; the shift step holds
// only until the response register is free. Failed operations change nothing.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_list
   import spl_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   spl_req_if.sink    req_bus,
   spl_rsp_if.source  rsp_bus
);

   cmd_type cmd;

   spl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   spl_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_bus.op),
      .req_index         (req_bus.index),
      .req_data          (req_bus.data),
      .req_priority      (req_bus.priority_req),
      .rsp_read_data     (rsp_bus.read_data),
      .rsp_read_priority (rsp_bus.read_priority),
      .rsp_status        (rsp_bus.status),
      .rsp_entry_count   (rsp_bus.entry_count)
   );

endmodule

`default_nettype wire

@@ rtl/spl_ctrl.sv @@
// ----------------------------------------------------------------------------
// spl_ctrl
// Sequencer: load, compare and shift steps, plus the response valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spl_ctrl
   import spl_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output cmd_type   cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_APPLY;
         end
         S_APPLY: begin
            // The result register must be free before the list changes.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = cmd.apply | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/spl_datapath.sv @@
// ----------------------------------------------------------------------------
// spl_datapath
// Row of list cells with per-cell compare and a one-step parallel shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spl_datapath
   import spl_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [INDEX_W-1:0]  req_index,
   input  wire logic [DATA_W-1:0]   req_data,
   input  wire logic [PRIO_W-1:0]   req_priority,
   output logic [DATA_W-1:0]        rsp_read_data,
   output logic [PRIO_W-1:0]        rsp_read_priority,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_entry_count
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int VEC_W = CAPACITY + 1;

   // Request registers.
   op_type                  op_ff;
   logic [CMP_W-1:0]        idx_ff;
   logic [DATA_WIDTH-1:0]   data_ff;
   logic [PRIO_W-1:0]       prio_ff;

   // List state.
   logic [DATA_WIDTH-1:0]   cell_data_ff [CAPACITY];
   logic [PRIO_W-1:0]       cell_prio_ff [CAPACITY];
   logic [DATA_WIDTH-1:0]   cell_data_in [CAPACITY];
   logic [PRIO_W-1:0]       cell_prio_in [CAPACITY];
   logic [CNT_W-1:0]        count_ff, count_in;

   // Compare-stage results.
   mode_type                mode_ff, mode_in;
   status_type              status_ff, status_in;
   logic [VEC_W-1:0]        mark_ff, mark_in;
   logic                    read_ok_ff, read_ok_in;

   // Response registers.
   logic [DATA_W-1:0]       rd_data_ff;
   logic [PRIO_W-1:0]       rd_prio_ff;
   status_type              rsp_status_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   logic                    full;
   logic                    idx_oob;
   logic [VEC_W-1:0]        at_count;
   logic [VEC_W-1:0]        at_index;
   logic [VEC_W-1:0]        prio_mark;
   logic [VEC_W-1:0]        from_pos;
   logic [DATA_WIDTH-1:0]   sel_data;
   logic [PRIO_W-1:0]       sel_prio;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(req_op);
         idx_ff  <= CMP_W'(req_index);
         data_ff <= DATA_WIDTH'(req_data);
         prio_ff <= req_priority;
      end
   end

   // Compare step: every cell checks itself against the request at once.
   always_comb begin
      full    = (count_ff == CNT_W'(CAPACITY));
      idx_oob = (idx_ff >= CMP_W'(count_ff));
      for (int i = 0; i < VEC_W; i++) begin
         at_count[i] = (CNT_W'(i) == count_ff);
         at_index[i] = (CMP_W'(i) == idx_ff);
         if (i < CAPACITY) begin
            prio_mark[i] = (CNT_W'(i) < count_ff) && (cell_prio_ff[i] > prio_ff);
         end else begin
            prio_mark[i] = 1'b0;
         end
      end
      // The slot at the count always stops the search, so a priority insert
      // that finds no larger priority lands at the end.
      prio_mark = prio_mark | at_count;

      mode_in    = MODE_NONE;
      status_in  = ST_OK;
      mark_in    = at_index;
      read_ok_in = 1'b0;
      case (op_ff)
         OP_APPEND: begin
            mark_in = at_count;
            if (full) status_in = ST_FULL;
            else      mode_in   = MODE_INSERT;
         end
         OP_PINSERT: begin
            mark_in = prio_mark;
            if (full) status_in = ST_FULL;
            else      mode_in   = MODE_INSERT;
         end
         OP_INSERT_AT: begin
            if (idx_oob)   status_in = ST_RANGE;
            else if (full) status_in = ST_FULL;
            else           mode_in   = MODE_INSERT;
         end
         OP_REMOVE: begin
            if (idx_oob) status_in = ST_RANGE;
            else         mode_in   = MODE_REMOVE;
         end
         OP_DROP_LAST: begin
            if (count_ff != '0) mode_in = MODE_DROP;
         end
         OP_READ: begin
            if (idx_oob) status_in  = ST_RANGE;
            else         read_ok_in = 1'b1;
         end
         default: begin
            mode_in = MODE_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         mode_ff    <= mode_in;
         status_ff  <= status_in;
         mark_ff    <= mark_in;
         read_ok_ff <= read_ok_in;
      end
   end

   // OR-ing the marks with their two's complement sets every bit from the
   // lowest mark upward: the cells at and above the target position.
   assign from_pos = mark_ff | (~mark_ff + VEC_W'(1));

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic below;
      if (g == 0) begin : g_first
         assign below = 1'b0;
      end else begin : g_rest
         assign below = from_pos[g-1];
      end

      always_comb begin
         cell_data_in[g] = cell_data_ff[g];
         cell_prio_in[g] = cell_prio_ff[g];
         case (mode_ff)
            MODE_INSERT: begin
               if (from_pos[g] && !below) begin
                  cell_data_in[g] = data_ff;
                  cell_prio_in[g] = prio_ff;
               end else if (below) begin
                  if (g > 0) begin
                     cell_data_in[g] = cell_data_ff[(g > 0) ? g - 1 : 0];
                     cell_prio_in[g] = cell_prio_ff[(g > 0) ? g - 1 : 0];
                  end
               end
            end
            MODE_REMOVE: begin
               if (from_pos[g] && (g < CAPACITY - 1)) begin
                  cell_data_in[g] = cell_data_ff[(g < CAPACITY - 1) ? g + 1 : g];
                  cell_prio_in[g] = cell_prio_ff[(g < CAPACITY - 1) ? g + 1 : g];
               end
            end
            default: begin
               cell_data_in[g] = cell_data_ff[g];
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (cmd.apply) begin
            cell_data_ff[g] <= cell_data_in[g];
            cell_prio_ff[g] <= cell_prio_in[g];
         end
      end
   end

   always_comb begin
      sel_data = '0;
      sel_prio = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (at_index[i]) begin
            sel_data = sel_data | cell_data_ff[i];
            sel_prio = sel_prio | cell_prio_ff[i];
         end
      end

      case (mode_ff)
         MODE_INSERT: count_in = count_ff + CNT_W'(1);
         MODE_REMOVE,
         MODE_DROP:   count_in = count_ff - CNT_W'(1);
         default:     count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rd_data_ff    <= read_ok_ff ? DATA_W'(sel_data) : '0;
         rd_prio_ff    <= read_ok_ff ? sel_prio : '0;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   assign rsp_read_data     = rd_data_ff;
   assign rsp_read_priority = rd_prio_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

`default_nettype wire

@@ rtl/spl_checker.sv @@
// ----------------------------------------------------------------------------
// spl_checker
// Port-level checks of the sorted priority list, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spl_checker
   import spl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [DATA_W-1:0]   rsp_read_data,
   input wire logic [PRIO_W-1:0]   rsp_read_priority,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [COUNT_W-1:0]  rsp_entry_count
);

   // Reset leaves no response pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A failed operation never returns entry contents.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_read_data == '0 && rsp_read_priority == '0))
      else $error("failed operation returned data");

   // A full status is only reported with the list at capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == COUNT_W'(CAPACITY)))
      else $error("full status with list not at capacity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_read_priority) &&
          $stable(rsp_status) && $stable(rsp_entry_count)))
      else $error("stalled response changed");

endmodule

bind sorted_priority_list spl_checker #(
   .CAPACITY (CAPACITY)
) u_spl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_read_data     (rsp_bus.read_data),
   .rsp_read_priority (rsp_bus.read_priority),
   .rsp_status        (rsp_bus.status),
   .rsp_entry_count   (rsp_bus.entry_count)
);

`default_nettype wire
